[hw/rtl/lrf_pkg.sv]
// Shared constants and types for the line rasterizer with framebuffer.
// Used by the divider, the top level and the port checker; depends on nothing.
package lrf_pkg;

    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 256;
    localparam int CHANNELS          = 3;
    localparam int COLOR_W           = 8;
    localparam int PIX_W             = CHANNELS * COLOR_W;
    localparam int COORD_W           = 16;
    localparam int IDX_W             = 16;
    // Pixel coordinates along either axis, signed, with headroom for extrapolation.
    localparam int CRD_W             = 14;
    // Interpolation numerator, its magnitude, and the divisor (16 * major length).
    localparam int NUM_W             = 34;
    localparam int DVD_W             = 33;
    localparam int DVS_W             = COORD_W + 4;

    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_res;

endpackage

[hw/rtl/line_rasterizer_framebuffer.sv]
// Top level: draw/read sequencer, incremental line walker and framebuffer.
// Depends on lrf_pkg, lrf_ram and lrf_div.
//
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------------------
//   in      | i_in_valid / o_in_stall   | action, x0, y0, x1, y1, rgb, pixel_index
//   out     | o_out_valid / i_out_stall | read_red, read_green, read_blue
//
// After reset the framebuffer is cleared one pixel per cycle, all SCREEN_WIDTH *
// SCREEN_HEIGHT pixels, with o_in_stall high throughout.
// A draw has setup and wrap-up around the serial divider that finds the first minor
// coordinate, which it starts, runs and finishes, and walks every major-axis step.
// A read goes through the registered RAM port.
// One item is in work at a time; a finished result waits in the output register
// while the next item is accepted, and a second result waits until that is taken.
module line_rasterizer_framebuffer import lrf_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic signed [COORD_W-1:0] i_x0,
    input  logic signed [COORD_W-1:0] i_y0,
    input  logic signed [COORD_W-1:0] i_x1,
    input  logic signed [COORD_W-1:0] i_y1,
    input  logic [COLOR_W-1:0]        i_red,
    input  logic [COLOR_W-1:0]        i_green,
    input  logic [COLOR_W-1:0]        i_blue,
    input  logic [IDX_W-1:0]          i_pixel_index,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [COLOR_W-1:0]        o_read_red,
    output logic [COLOR_W-1:0]        o_read_green,
    output logic [COLOR_W-1:0]        o_read_blue
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(SCREEN_WIDTH);
    localparam int RW    = $clog2(SCREEN_HEIGHT);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_SWAP  = 14'b00000000000100,
        S_ORDER = 14'b00000000001000,
        S_MUL1  = 14'b00000000010000,
        S_MUL2  = 14'b00000000100000,
        S_DIVGO = 14'b00000001000000,
        S_DIV   = 14'b00000010000000,
        S_FIX   = 14'b00000100000000,
        S_STEP  = 14'b00001000000000,
        S_FLUSH = 14'b00010000000000,
        S_READ  = 14'b00100000000000,
        S_RWAIT = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr;

    // Latched item.
    logic signed [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [PIX_W-1:0]          r_rgb;
    logic [IDX_W-1:0]          r_idx;

    // Endpoints after the steep swap, then after ordering by the major axis.
    logic                      r_steep;
    logic signed [COORD_W-1:0] r_amaj, r_amin, r_bmaj, r_bmin;
    logic signed [COORD_W-1:0] r_ax, r_ay;
    logic signed [COORD_W:0]   r_dy;
    logic [COORD_W-1:0]        r_den;
    logic signed [CRD_W-1:0]   r_m, r_mend;

    // Walker state: minor = floor part r_f plus remainder r_r over the divisor.
    logic signed [NUM_W-1:0]   r_num;
    logic signed [CRD_W-1:0]   r_f;
    logic [DVS_W-1:0]          r_r;
    logic signed [1:0]         r_fs;
    logic [DVS_W-1:0]          r_rs;

    logic                      r_pix_valid;
    logic [CW-1:0]             r_pix_col;
    logic [RW-1:0]             r_pix_row;

    logic [PIX_W-1:0]          r_pend;
    logic                      r_out_valid;
    logic [PIX_W-1:0]          r_res;

    logic in_acc;
    logic out_load;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Steep test on the raw fixed-point differences.
    logic signed [COORD_W:0] dx_s, dy_s;
    logic [COORD_W:0]        adx, ady;
    logic                    steep;

    assign dx_s  = (COORD_W+1)'(r_x1) - (COORD_W+1)'(r_x0);
    assign dy_s  = (COORD_W+1)'(r_y1) - (COORD_W+1)'(r_y0);
    assign adx   = dx_s[COORD_W] ? -dx_s : dx_s;
    assign ady   = dy_s[COORD_W] ? -dy_s : dy_s;
    assign steep = adx < ady;

    // Ordering so the major coordinate rises.
    logic                      swp;
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic [COORD_W:0]          den_full;
    logic [COORD_W-1:0]        den_eff;
    logic signed [CRD_W-1:0]   m0, mend;

    assign swp      = r_amaj > r_bmaj;
    assign ax       = swp ? r_bmaj : r_amaj;
    assign ay       = swp ? r_bmin : r_amin;
    assign bx       = swp ? r_amaj : r_bmaj;
    assign by       = swp ? r_amin : r_bmin;
    assign den_full = (COORD_W+1)'(bx) - (COORD_W+1)'(ax);
    // A zero-length line uses a unit length; its minor difference is zero too.
    assign den_eff  = (den_full == '0) ? COORD_W'(1) : den_full[COORD_W-1:0];
    // Start truncates toward zero, end floors.
    assign m0       = CRD_W'(ax >>> 4) + CRD_W'(ax[COORD_W-1] && (ax[3:0] != 4'd0));
    assign mend     = CRD_W'(bx >>> 4);

    // Shared multiplier: ay * den first, then dy * (16 * m0 - ax).
    logic signed [COORD_W:0]   mul_a;
    logic signed [COORD_W+1:0] mul_b;
    logic signed [COORD_W+1:0] off;
    logic signed [2*COORD_W+2:0] prod;

    assign off   = $signed({r_m, 4'b0000}) - (COORD_W+2)'(r_ax);
    assign mul_a = (r_state == S_MUL1) ? (COORD_W+1)'(r_ay) : r_dy;
    assign mul_b = (r_state == S_MUL1) ? $signed({2'b00, r_den}) : off;
    assign prod  = mul_a * mul_b;

    // Divider for the initial minor coordinate.
    logic [NUM_W-1:0] num_mag;
    logic [DVS_W-1:0] d_val;
    t_div_res         div_res;

    assign num_mag = r_num[NUM_W-1] ? -r_num : r_num;
    assign d_val   = {r_den, 4'b0000};

    lrf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVGO),
        .i_dividend (num_mag[DVD_W-1:0]),
        .i_divisor  (d_val),
        .o_res      (div_res)
    );

    // Turn the magnitude quotient into floor and nonnegative remainder, and
    // split the per-step increment 16*dy the same way.
    logic                    neg, rem_nz, dy_neg, unit;
    logic signed [CRD_W-1:0] q_t, f_fix;
    logic [DVS_W-1:0]        r_fix, rs_fix, mdy16;
    logic signed [1:0]       fs_fix;
    logic [COORD_W:0]        mdy;

    assign neg    = r_num[NUM_W-1];
    assign rem_nz = (div_res.rem != '0);
    assign q_t    = div_res.quot[CRD_W-1:0];
    assign f_fix  = neg ? (rem_nz ? ~q_t : -q_t) : q_t;
    assign r_fix  = (neg && rem_nz) ? d_val - div_res.rem : div_res.rem;
    assign dy_neg = r_dy[COORD_W];
    assign mdy    = dy_neg ? -r_dy : r_dy;
    assign unit   = (mdy[COORD_W-1:0] == r_den);
    assign mdy16  = {mdy[COORD_W-1:0], 4'b0000};
    assign fs_fix = dy_neg ? 2'sb11 : (unit ? 2'sb01 : 2'sb00);
    assign rs_fix = unit ? '0 : (dy_neg ? d_val - mdy16 : mdy16);

    // One pixel per step: round half away from zero, then clip.
    logic [DVS_W:0]          r2, dext, r_sum, r_sub;
    logic                    rnd_up, wrap, inb;
    logic signed [CRD_W-1:0] n_coord, col, row, f_next;
    logic [DVS_W-1:0]        r_next;

    assign r2      = {r_r, 1'b0};
    assign dext    = {1'b0, d_val};
    assign rnd_up  = (r2 > dext) || ((r2 == dext) && !r_f[CRD_W-1]);
    assign n_coord = r_f + CRD_W'(rnd_up);
    assign col     = r_steep ? n_coord : r_m;
    assign row     = r_steep ? r_m : n_coord;
    assign inb     = !col[CRD_W-1] && (col[CRD_W-2:0] < (CRD_W-1)'(SCREEN_WIDTH))
                  && !row[CRD_W-1] && (row[CRD_W-2:0] < (CRD_W-1)'(SCREEN_HEIGHT));
    assign r_sum   = {1'b0, r_r} + {1'b0, r_rs};
    assign wrap    = r_sum >= dext;
    assign r_sub   = r_sum - dext;
    assign r_next  = wrap ? r_sub[DVS_W-1:0] : r_sum[DVS_W-1:0];
    assign f_next  = r_f + {{(CRD_W-2){r_fs[1]}}, r_fs} + CRD_W'(wrap);

    // Framebuffer; rows are stored bottom-up.
    logic [RW-1:0]    mem_row;
    logic [AW-1:0]    pix_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] ram_wdata;
    logic [PIX_W-1:0] ram_rdata;
    logic             idx_ok;

    assign mem_row   = RW'(SCREEN_HEIGHT - 1) - r_pix_row;
    assign pix_addr  = AW'(mem_row) * AW'(SCREEN_WIDTH) + AW'(r_pix_col);
    assign ram_we    = (r_state == S_CLEAR) || r_pix_valid;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : pix_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_rgb;
    assign idx_ok    = 32'(r_idx) < 32'(DEPTH);

    lrf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_fb (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_idx)),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) n_state = (i_action == ACT_READ) ? S_READ : S_SWAP;
            end
            S_SWAP:  n_state = S_ORDER;
            S_ORDER: n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIV;
            S_DIV: begin
                if (div_res.done) n_state = S_FIX;
            end
            S_FIX: begin
                n_state = (r_m > r_mend) ? S_DONE : S_STEP;
            end
            S_STEP: begin
                if (r_m == r_mend) n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_DONE;
            S_READ:  n_state = S_RWAIT;
            S_RWAIT: n_state = S_DONE;
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pix_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pix_valid <= (r_state == S_STEP) && inb;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x0   <= i_x0;
            r_y0   <= i_y0;
            r_x1   <= i_x1;
            r_y1   <= i_y1;
            r_rgb  <= {i_red, i_green, i_blue};
            r_idx  <= i_pixel_index;
            r_pend <= '0;
        end
        if (r_state == S_SWAP) begin
            r_steep <= steep;
            r_amaj  <= steep ? r_y0 : r_x0;
            r_amin  <= steep ? r_x0 : r_y0;
            r_bmaj  <= steep ? r_y1 : r_x1;
            r_bmin  <= steep ? r_x1 : r_y1;
        end
        if (r_state == S_ORDER) begin
            r_ax   <= ax;
            r_ay   <= ay;
            r_dy   <= (COORD_W+1)'(by) - (COORD_W+1)'(ay);
            r_den  <= den_eff;
            r_m    <= m0;
            r_mend <= mend;
        end
        if (r_state == S_MUL1) begin
            r_num <= NUM_W'(prod);
        end
        if (r_state == S_MUL2) begin
            r_num <= r_num + NUM_W'(prod);
        end
        if (r_state == S_FIX) begin
            r_f  <= f_fix;
            r_r  <= r_fix;
            r_fs <= fs_fix;
            r_rs <= rs_fix;
        end
        if (r_state == S_STEP) begin
            r_pix_col <= col[CW-1:0];
            r_pix_row <= row[RW-1:0];
            r_f       <= f_next;
            r_r       <= r_next;
            r_m       <= r_m + 1'b1;
        end
        if (r_state == S_RWAIT) begin
            r_pend <= idx_ok ? ram_rdata : '0;
        end
        if (out_load) begin
            r_res <= r_pend;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_red   = r_res[2*COLOR_W +: COLOR_W];
    assign o_read_green = r_res[COLOR_W +: COLOR_W];
    assign o_read_blue  = r_res[0 +: COLOR_W];

endmodule

[hw/rtl/lrf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module lrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lrf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lrf_pkg for operand widths and the result struct.
module lrf_div import lrf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_quot[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quot <= {r_quot[DVD_W-2:0], ge};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

[hw/rtl/lrf_chk.sv]
// Port-level checker for the line rasterizer, bound to the top level.
// Depends on lrf_pkg for the color width.
module lrf_chk import lrf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [COLOR_W-1:0] o_read_red,
    input logic [COLOR_W-1:0] o_read_green,
    input logic [COLOR_W-1:0] o_read_blue
);

    // Items accepted whose result has not yet been taken.
    logic [1:0] r_owed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
        end else begin
            r_owed <= r_owed + 2'(i_in_valid && !o_in_stall)
                             - 2'(o_out_valid && !i_out_stall);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("block not quiet after reset");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while another is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_red)
            && $stable(o_read_green) && $stable(o_read_blue)))
        else $error("stalled result changed");

    a_owed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owed != 2'd3)
        else $error("more than two items outstanding");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_owed != 2'd0))
        else $error("result shown without an accepted item");

endmodule

bind line_rasterizer_framebuffer lrf_chk u_lrf_chk (.*);
